// ===== rtl/core/mkat_pkg.sv =====
// mkat_pkg: shared types and constants of the mac keepalive aging table
// no dependencies; imported by mkat_cell and mac_keepalive_aging_table_unit
`default_nettype none

package mkat_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int MAC_W             = 48;
	localparam int TIME_W            = 32;
	localparam int SEQ_W             = 32;
	localparam int KA_W              = 16;
	localparam int APB_DATA_W        = 32;
	localparam int APB_ADDR_W        = 3;

	localparam logic [TIME_W-1:0]     GRACE_SECONDS   = 32'd10;
	localparam logic [SEQ_W-1:0]      SEQUENCE_START  = 32'd1000;
	localparam logic [KA_W-1:0]       KEEPALIVE_RESET = 16'd30;
	localparam logic [APB_ADDR_W-1:0] ADDR_KEEPALIVE  = 3'd0;

	// one table entry as it travels around the ring
	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] expiry;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/mkat_cell.sv =====
// mkat_cell: one storage cell of the rotating entry ring
// depends on mkat_pkg for entry_t
`default_nettype none

module mkat_cell
	import mkat_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   shift_en,
	input  wire entry_t d,
	output entry_t      q
);

	entry_t entry_q;

	// payload only, contents undefined until written
	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

`default_nettype wire

// ===== rtl/core/mac_keepalive_aging_table_unit.sv =====
// mac_keepalive_aging_table_unit: top level of the mac keepalive aging table
// depends on mkat_pkg and mkat_cell
`default_nettype none

// Each input transaction stands for one elapsed second and may carry a heard
// MAC address. The table is a ring of TABLE_ENTRIES cells that rotates by one
// cell per cycle past a single head processor. During one full rotation the
// head refreshes the expiry of a matching stored MAC (now + keepalive + 10),
// appends an unknown MAC in the first free slot while room remains, and for
// every occupied entry whose nonzero expiry is at or before now emits a delete
// transaction (MAC, sequence number starting at 1000) and zeroes that expiry.
// The last delete of a second carries last = 1; a second with nothing expired
// produces no output. An item occupies the block for one rotation of the ring
// plus accept and flush, longer while the output stalls, since the ring holds
// its position whenever a new delete cannot be parked. in_stall stays high for
// the whole walk. No clearing pass is needed after reset: count_q marks which
// cells hold entries. keepalive_seconds sits at APB byte address 0, reset value
// 30; other addresses read as zero and ignore writes.
module mac_keepalive_aging_table_unit
	import mkat_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// apb configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,

	// input channel, one transaction per second
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  mac_valid,
	input  wire logic [MAC_W-1:0]      mac,

	// delete channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [MAC_W-1:0]      expired_mac,
	output logic      [SEQ_W-1:0]      sequence_res,
	output logic                       last
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t             state_q;
	logic [KA_W-1:0]    keepalive_q;
	logic [TIME_W-1:0]  now_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic               found_q;

	// latched input transaction
	logic               item_valid_q;
	logic [MAC_W-1:0]   item_mac_q;
	logic [TIME_W-1:0]  deadline_q;

	// parked delete, waits until its last flag is known
	logic               pend_v_q;
	logic [MAC_W-1:0]   pend_mac_q;
	logic [SEQ_W-1:0]   pend_seq_q;

	// output register
	logic               out_v_q;
	logic [MAC_W-1:0]   out_mac_q;
	logic [SEQ_W-1:0]   out_seq_q;
	logic               out_last_q;

	// ---------------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------------
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_KEEPALIVE);

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_KEEPALIVE) begin
			prdata = APB_DATA_W'(keepalive_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keepalive_q <= KEEPALIVE_RESET;
		end else if (cfg_wr) begin
			keepalive_q <= pwdata[KA_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// entry ring: cell i takes from cell i+1, the tail takes the head result
	// ---------------------------------------------------------------------
	entry_t ring_q [TABLE_ENTRIES];
	entry_t wb_entry;
	logic   shift_en;

	for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_ring
		entry_t cell_d;
		if (gi == TABLE_ENTRIES - 1) begin : g_tail
			assign cell_d = wb_entry;
		end else begin : g_link
			assign cell_d = ring_q[gi+1];
		end
		mkat_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (cell_d),
			.q        (ring_q[gi])
		);
	end

	// ---------------------------------------------------------------------
	// head processor: the entry at the head during step k is table index k
	// ---------------------------------------------------------------------
	entry_t            head;
	logic              occupied;
	logic              do_append;
	logic              do_match;
	logic [MAC_W-1:0]  new_mac;
	logic [TIME_W-1:0] new_exp;
	logic              hit;
	logic              can_move;
	logic              advance;
	logic              scanning;
	logic              in_accept;

	assign head      = ring_q[0];
	assign scanning  = (state_q == ST_SCAN);
	assign occupied  = CNT_W'(idx_q) < count_q;
	// first free slot, reached only after every stored entry was compared
	assign do_append = !occupied && (CNT_W'(idx_q) == count_q) && item_valid_q && !found_q;
	assign do_match  = occupied && item_valid_q && !found_q && (head.mac == item_mac_q);
	assign new_mac   = do_append ? item_mac_q : head.mac;
	assign new_exp   = (do_append || do_match) ? deadline_q : head.expiry;
	assign hit       = scanning && (occupied || do_append) && (new_exp != '0)
	                   && (new_exp <= now_q);

	assign can_move  = !out_v_q || !out_stall;
	// hold the ring when a new delete finds the parking slot still blocked
	assign advance   = !(hit && pend_v_q && !can_move);
	assign shift_en  = scanning && advance;

	assign wb_entry.mac    = new_mac;
	assign wb_entry.expiry = hit ? '0 : new_exp;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// ---------------------------------------------------------------------
	// control
	// ---------------------------------------------------------------------
	logic flush_move;
	logic scan_move;
	logic out_take;
	logic [TIME_W-1:0] now_next;

	assign now_next   = now_q + 1'b1;
	assign scan_move  = shift_en && hit && pend_v_q;
	assign flush_move = (state_q == ST_FLUSH) && pend_v_q && can_move;
	assign out_take   = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			now_q    <= '0;
			seq_q    <= SEQUENCE_START;
			count_q  <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						now_q   <= now_next;
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (shift_en) begin
						if (do_match || do_append) begin
							found_q <= 1'b1;
						end
						if (do_append) begin
							count_q <= count_q + 1'b1;
						end
						if (hit) begin
							pend_v_q <= 1'b1;
							seq_q    <= seq_q + 1'b1;
						end
						if (idx_q == LAST_IDX) begin
							idx_q   <= '0;
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (can_move) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (scan_move || flush_move) begin
				out_v_q <= 1'b1;
			end else if (out_take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_valid_q <= mac_valid;
			item_mac_q   <= mac;
			deadline_q   <= now_next + TIME_W'(keepalive_q) + GRACE_SECONDS;
		end
		if (shift_en && hit) begin
			pend_mac_q <= new_mac;
			pend_seq_q <= seq_q;
		end
		if (scan_move || flush_move) begin
			out_mac_q  <= pend_mac_q;
			out_seq_q  <= pend_seq_q;
			out_last_q <= flush_move;
		end
	end

	assign out_valid    = out_v_q;
	assign expired_mac  = out_mac_q;
	assign sequence_res = out_seq_q;
	assign last         = out_last_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond table size");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("parked delete left behind at end of a second");

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		(shift_en && hit) |=> (seq_q == $past(seq_q) + 1'b1))
		else $error("sequence number did not advance on a delete");

	a_seq_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(shift_en && hit) |=> $stable(seq_q))
		else $error("sequence number moved without a delete");

endmodule

`default_nettype wire

// ===== tb/mac_keepalive_aging_table_unit_tb.sv =====
// mac_keepalive_aging_table_unit_tb: self-checking testbench of the mac keepalive aging table
// needs mkat_pkg and mac_keepalive_aging_table_unit; predicts every delete transaction
// from a mirror of the table, checks it field by field and fails on mismatch or timeout
module mac_keepalive_aging_table_unit_tb;
	import mkat_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES          = TABLE_ENTRIES_DEF;
	// one rotation of the ring plus accept and flush, taken twice over
	localparam int TAIL_CYCLES      = 2 * (ENTRIES + 2) + 4;
	localparam int HOLDOFF_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int PHASE_SECONDS    = 60;
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

	// one input transaction: one elapsed second, maybe with a heard mac
	typedef struct {
		logic             heard;
		logic [MAC_W-1:0] addr;
	} second_t;

	// one expected delete transaction
	typedef struct packed {
		logic [MAC_W-1:0] addr;
		logic [SEQ_W-1:0] seq;
		logic             is_last;
	} delete_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	// dut signals, inputs known from time zero
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [APB_ADDR_W-1:0] paddr        = '0;
	logic [APB_DATA_W-1:0] pwdata       = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic                  mac_valid    = 1'b0;
	logic [MAC_W-1:0]      mac          = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [MAC_W-1:0]      expired_mac;
	logic [SEQ_W-1:0]      sequence_res;
	logic                  last;

	// mirror of the table state, advanced once per accepted second
	logic [MAC_W-1:0]  mirror_mac [ENTRIES];
	logic [TIME_W-1:0] mirror_expiry [ENTRIES];
	int                mirror_count     = 0;
	logic [TIME_W-1:0] mirror_now       = '0;
	logic [SEQ_W-1:0]  mirror_seq       = SEQUENCE_START;
	logic [KA_W-1:0]   mirror_keepalive = KEEPALIVE_RESET;

	second_t     pending_seconds[$];
	delete_t     expected_deletes[$];
	int          seconds_queued   = 0;
	int          seconds_taken    = 0;
	int          mismatch_count   = 0;
	int          quiet_cycles     = 0;
	bit          holdoff_req      = 1'b0;
	bit          holdoff_done     = 1'b0;
	int          holdoff_left     = 0;
	stall_mode_t stall_mode       = STALL_NONE;
	int          mode_left        = 0;
	int          burst_left       = 0;
	int          gap_left         = 0;
	logic [MAC_W-1:0] mac_pool [ENTRIES];

	mac_keepalive_aging_table_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mac_valid    (mac_valid),
		.mac          (mac),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.expired_mac  (expired_mac),
		.sequence_res (sequence_res),
		.last         (last)
	);

	always #4 clk = ~clk;

	// one line per mismatch
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// advance the mirror by one second and queue the deletes it causes
	function automatic void age_one_second(input logic heard, input logic [MAC_W-1:0] addr);
		logic [TIME_W-1:0] deadline;
		bit                hit;
		int                n;
		delete_t           del;
		mirror_now = mirror_now + 1'b1;
		if (heard) begin
			// now + keepalive + grace, wrapping at 32 bits
			deadline = mirror_now + {16'd0, mirror_keepalive} + GRACE_SECONDS;
			hit = 1'b0;
			for (int i = 0; i < mirror_count; i++) begin
				if (!hit && mirror_mac[i] == addr) begin
					mirror_expiry[i] = deadline;
					hit = 1'b1;
				end
			end
			// unknown mac is appended while room remains, dropped when the table is full
			if (!hit && mirror_count < ENTRIES) begin
				mirror_mac[mirror_count] = addr;
				mirror_expiry[mirror_count] = deadline;
				mirror_count++;
			end
		end
		// index-order scan; zero expiry means nothing pending
		n = 0;
		for (int i = 0; i < mirror_count; i++) begin
			if (mirror_expiry[i] != '0 && mirror_expiry[i] <= mirror_now) begin
				del.addr = mirror_mac[i];
				del.seq = mirror_seq;
				del.is_last = 1'b0;
				expected_deletes.push_back(del);
				mirror_seq = mirror_seq + 1'b1;
				mirror_expiry[i] = '0;
				n++;
			end
		end
		// flag the final delete of this second
		if (n > 0) begin
			del = expected_deletes.pop_back();
			del.is_last = 1'b1;
			expected_deletes.push_back(del);
		end
	endfunction

	function automatic logic [MAC_W-1:0] random_mac();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[MAC_W-1:0];
	endfunction

	task automatic queue_second(input logic heard, input logic [MAC_W-1:0] addr);
		second_t s;
		s.heard = heard;
		s.addr = addr;
		pending_seconds.push_back(s);
		seconds_queued++;
	endtask

	// wait until every second is taken, every delete seen, and the walk has drained
	task automatic settle();
		while (seconds_taken != seconds_queued) @(posedge clk);
		while (expected_deletes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// apb write: setup, then access; register written at the access edge
	task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// apb read and compare; data sampled mid access cycle
	task automatic apb_check(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] want);
		logic [APB_DATA_W-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			report_mismatch("register read", 64'(got), 64'(want));
	endtask

	// keepalive change only with the block idle, then read back
	task automatic set_keepalive(input logic [KA_W-1:0] v);
		settle();
		apb_write(ADDR_KEEPALIVE, {16'd0, v});
		mirror_keepalive = v;
		apb_check(ADDR_KEEPALIVE, {16'd0, v});
	endtask

	// random seconds: mostly known macs (refresh), some unknown (dropped, table full),
	// some with no mac heard
	task automatic random_phase(input logic [KA_W-1:0] v, input bit with_holdoff);
		int base;
		int r;
		set_keepalive(v);
		base = seconds_taken;
		for (int n = 0; n < PHASE_SECONDS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				queue_second(1'b0, random_mac());
			else if (r < 27)
				queue_second(1'b1, random_mac());
			else
				queue_second(1'b1, mac_pool[$urandom_range(0, ENTRIES - 1)]);
		end
		// start the long receiver hold-off once refreshed entries begin to expire
		if (with_holdoff) begin
			while (seconds_taken < base + 12) @(posedge clk);
			holdoff_req = 1'b1;
		end
	endtask

	// sender: bursts of random length with random gaps; payload held while stalled
	always @(posedge clk) begin : drive
		second_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				age_one_second(mac_valid, mac);
				seconds_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_seconds.size() != 0) begin
					nxt = pending_seconds.pop_front();
					in_valid <= 1'b1;
					mac_valid <= nxt.heard;
					mac <= nxt.addr;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						// a third of the bursts run back to back
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern in stretches of random mode, plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else if (holdoff_req && !holdoff_done) begin
			holdoff_done = 1'b1;
			holdoff_left = HOLDOFF_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(16, 80);
				stall_mode = stall_mode_t'($urandom_range(0, 2));
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE: begin
					out_stall <= 1'b0;
				end
				STALL_LIGHT: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					out_stall <= ($urandom_range(0, 3) != 0);
				end
			endcase
		end
	end

	// delete channel checker: each transaction against the oldest expectation
	always @(posedge clk) begin : check_deletes
		delete_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_deletes.size() == 0) begin
				report_mismatch("delete with nothing pending", 64'(expired_mac), '0);
			end else begin
				want = expected_deletes.pop_front();
				if (expired_mac !== want.addr)
					report_mismatch("expired_mac", 64'(expired_mac), 64'(want.addr));
				if (sequence_res !== want.seq)
					report_mismatch("sequence_res", 64'(sequence_res), 64'(want.seq));
				if (last !== want.is_last)
					report_mismatch("last", 64'(last), 64'(want.is_last));
			end
		end
	end

	// watchdog: too long with no transaction on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset value, then a write to an unmapped address must change nothing
		apb_check(ADDR_KEEPALIVE, {16'd0, KEEPALIVE_RESET});
		apb_write(ADDR_UNMAPPED, '1);
		apb_check(ADDR_UNMAPPED, '0);
		apb_check(ADDR_KEEPALIVE, {16'd0, KEEPALIVE_RESET});

		// the macs that will fill the table: extremes and alternating patterns first
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		mac_pool[2] = {24{2'b10}};
		mac_pool[3] = {24{2'b01}};
		for (int i = 4; i < ENTRIES; i++)
			mac_pool[i] = random_mac();

		// fill the table so every entry expires at second 28: insert, refresh of the
		// same mac, then the rest, lowering the keepalive one step per second
		for (int i = 0; i <= ENTRIES; i++) begin
			set_keepalive(KA_W'(17 - i));
			queue_second(1'b1, mac_pool[(i < 2) ? 0 : i - 1]);
		end
		// table full: an unknown mac is dropped; zero keepalive is the low extreme
		set_keepalive('0);
		queue_second(1'b1, random_mac());
		// nothing heard, every mac bit set
		queue_second(1'b0, '1);
		// quiet seconds up to the one where all sixteen entries expire together
		for (int i = 19; i < 28; i++)
			queue_second(1'b0, random_mac());

		// random part under several keepalive settings, the extremes among them
		random_phase('0, 1'b1);
		random_phase('1, 1'b0);
		random_phase(16'd5, 1'b0);
		random_phase(KA_W'($urandom_range(0, 40)), 1'b0);
		random_phase(16'd1, 1'b0);
		random_phase(KEEPALIVE_RESET, 1'b0);

		settle();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
